// File: hw/rtl/tiorq_pkg.sv
// Package for the tagged I/O request queue: sizes, codes and payload types.
// Used by every module of the block; depends on nothing.
package tiorq_pkg;

    localparam int TableDepth   = 256;
    localparam int SlotCapacity = 64;
    localparam int AutoLevel    = 32;
    localparam int IdxW         = $clog2(TableDepth);
    localparam int FillW        = IdxW + 1;
    localparam int PendW        = 7;
    localparam int DoneW        = 9;

    localparam logic [2:0] OP_ENQUEUE  = 3'd0;
    localparam logic [2:0] OP_CANCEL   = 3'd1;
    localparam logic [2:0] OP_SUBMIT   = 3'd2;
    localparam logic [2:0] OP_QUERY    = 3'd3;
    localparam logic [2:0] OP_DISPATCH = 3'd4;
    localparam logic [2:0] OP_COMPLETE = 3'd5;

    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_INFLIGHT  = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_ERROR     = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] req_tag;
        logic [15:0] file_handle;
        logic [63:0] source_offset;
        logic [31:0] byte_length;
        logic [63:0] dest_address;
        logic        args_valid;
        logic        io_ok;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  entry_status;
        logic        dispatch_valid;
        logic [63:0] dispatch_tag;
        logic [15:0] dispatch_file;
        logic [63:0] dispatch_offset;
        logic [31:0] dispatch_length;
        logic [63:0] dispatch_dest;
        logic [6:0]  pending_count;
        logic        busy_flag;
        logic [8:0]  done_count;
        logic        gate_open;
    } t_rsp;

    // One table row: request payload plus its status.
    typedef struct packed {
        logic [63:0] tag;
        logic [15:0] file;
        logic [63:0] offset;
        logic [31:0] length;
        logic [63:0] dest;
        logic [2:0]  state;
    } t_entry;

    // Memory port from the sequencer to the table.
    typedef struct packed {
        logic            rd_en;
        logic [IdxW-1:0] rd_addr;
        logic            wr_en;
        logic [IdxW-1:0] wr_addr;
        t_entry          wr_data;
    } t_mem_cmd;

endpackage

// File: hw/rtl/tiorq_table.sv
// Request table memory: one synchronous write port and one registered read port.
// Depends on tiorq_pkg.
module tiorq_table (
    input  logic                i_clk,
    input  tiorq_pkg::t_mem_cmd i_cmd,
    output tiorq_pkg::t_entry   o_rd_data
);
    import tiorq_pkg::*;

    t_entry r_mem [TableDepth];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

endmodule

// File: hw/rtl/tiorq_ctrl.sv
// Sequencer of the request queue: scans the table for tags and pending rows.
// Depends on tiorq_pkg; drives the tiorq_table port.
module tiorq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  tiorq_pkg::t_req     i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output tiorq_pkg::t_rsp     o_rsp,
    output tiorq_pkg::t_mem_cmd o_cmd,
    input  tiorq_pkg::t_entry   i_rd_data
);
    import tiorq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_req            r_req;
    logic [FillW-1:0] r_fill, r_scan;
    logic            r_rd_pend;
    logic [IdxW-1:0] r_rd_idx;
    logic            r_hit;
    logic [IdxW-1:0] r_hit_idx;
    t_entry          r_hit_ent;
    logic [PendW-1:0] r_pend;
    logic [DoneW-1:0] r_done;
    logic            r_busy, r_gate, r_auto;
    logic [IdxW-1:0] r_busy_idx;
    t_rsp            r_rsp;
    logic            r_ovalid;

    logic [FillW-1:0] n_fill;
    logic [IdxW-1:0]  n_busy_idx;
    t_rsp             n_rsp;

    logic            match;
    logic            scan_end;
    logic            find_pend;

    // Dispatch scans for the first pending row; complete takes the busy row it
    // reads first; the others scan for the tag.
    assign find_pend = (r_req.operation == OP_DISPATCH);
    assign match = (r_req.operation == OP_COMPLETE) ? 1'b1
                 : find_pend ? (i_rd_data.state == ST_PENDING)
                             : (i_rd_data.tag == r_req.req_tag);
    assign scan_end = (r_scan == r_fill);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    // Memory read during scans, write on update.
    always_comb begin
        o_cmd = '0;
        o_cmd.rd_en   = (r_state == S_SCAN) && !scan_end && !r_hit;
        o_cmd.rd_addr = r_scan[IdxW-1:0];
        o_cmd.wr_addr = r_hit_idx;
        o_cmd.wr_data = r_hit_ent;
        if (r_state == S_DONE) begin
            unique case (r_req.operation)
                OP_ENQUEUE: begin
                    o_cmd.wr_en   = !r_hit && r_req.byte_length != '0 && r_req.args_valid
                        && ({1'b0, r_pend} + (PendW+1)'(r_busy)) < (PendW+1)'(SlotCapacity)
                        && r_fill < FillW'(TableDepth);
                    o_cmd.wr_addr = r_fill[IdxW-1:0];
                    o_cmd.wr_data = '{tag: r_req.req_tag, file: r_req.file_handle,
                                      offset: r_req.source_offset,
                                      length: r_req.byte_length,
                                      dest: r_req.dest_address, state: ST_PENDING};
                end
                OP_CANCEL: begin
                    o_cmd.wr_en = r_hit && r_hit_ent.state == ST_PENDING;
                    o_cmd.wr_data.state = ST_CANCELLED;
                end
                OP_DISPATCH: begin
                    o_cmd.wr_en = r_hit && !r_busy && r_gate;
                    o_cmd.wr_data.state = ST_INFLIGHT;
                end
                OP_COMPLETE: begin
                    o_cmd.wr_en = r_busy && r_hit;
                    o_cmd.wr_data.state = r_req.io_ok ? ST_DONE : ST_ERROR;
                end
                default: o_cmd.wr_en = 1'b0;
            endcase
        end
    end

    // Result of the request and the counters after it.
    always_comb begin
        n_fill     = r_fill;
        n_busy_idx = r_busy_idx;
        n_rsp      = '0;
        n_rsp.entry_status  = ST_ERROR;
        n_rsp.pending_count = r_pend;
        n_rsp.busy_flag     = r_busy;
        n_rsp.done_count    = r_done;
        n_rsp.gate_open     = r_gate;
        unique case (r_req.operation)
            OP_ENQUEUE: begin
                if (o_cmd.wr_en) begin
                    n_fill = r_fill + 1'b1;
                    n_rsp.pending_count = r_pend + 1'b1;
                    n_rsp.accepted = 1'b1;
                    n_rsp.entry_status = ST_PENDING;
                    if (r_auto && (r_pend + 1'b1) >= PendW'(AutoLevel)) begin
                        n_rsp.gate_open = 1'b1;
                    end
                end else if (r_hit) begin
                    n_rsp.entry_status = r_hit_ent.state;
                end
            end
            OP_CANCEL: begin
                if (r_hit) n_rsp.entry_status = r_hit_ent.state;
                if (o_cmd.wr_en) begin
                    n_rsp.pending_count = r_pend - 1'b1;
                    n_rsp.accepted = 1'b1;
                    n_rsp.entry_status = ST_CANCELLED;
                end
            end
            OP_SUBMIT: begin
                if (!r_gate && r_pend != '0) begin
                    n_rsp.gate_open = 1'b1;
                    n_rsp.accepted = 1'b1;
                end
            end
            OP_QUERY: begin
                if (r_hit) n_rsp.entry_status = r_hit_ent.state;
            end
            OP_DISPATCH: begin
                if (!r_busy && r_gate) begin
                    if (!r_hit) begin
                        n_rsp.gate_open = 1'b0;
                    end else begin
                        n_rsp.pending_count = r_pend - 1'b1;
                        n_rsp.busy_flag = 1'b1;
                        n_busy_idx = r_hit_idx;
                        n_rsp.dispatch_valid = 1'b1;
                        n_rsp.entry_status = ST_INFLIGHT;
                        n_rsp.dispatch_tag = r_hit_ent.tag;
                        n_rsp.dispatch_file = r_hit_ent.file;
                        n_rsp.dispatch_offset = r_hit_ent.offset;
                        n_rsp.dispatch_length = r_hit_ent.length;
                        n_rsp.dispatch_dest = r_hit_ent.dest;
                    end
                end
            end
            OP_COMPLETE: begin
                if (r_busy) begin
                    n_rsp.busy_flag = 1'b0;
                    n_rsp.entry_status = r_req.io_ok ? ST_DONE : ST_ERROR;
                    if (r_req.io_ok && r_done != '1) begin
                        n_rsp.done_count = r_done + 1'b1;
                    end
                    if (r_pend == '0) begin
                        n_rsp.gate_open = 1'b0;
                    end
                end
            end
            default: n_rsp.accepted = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_SCAN;
            S_SCAN: if ((scan_end && !r_rd_pend) || r_hit) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, scan progress and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0; r_pend <= '0; r_done <= '0;
            r_busy <= 1'b0; r_gate <= 1'b0; r_busy_idx <= '0;
            r_auto <= 1'b1; r_ovalid <= 1'b0; r_rd_pend <= 1'b0;
            r_hit <= 1'b0; r_scan <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_auto <= i_cfg_wdata;
            r_rd_pend <= o_cmd.rd_en;
            r_rd_idx  <= r_scan[IdxW-1:0];
            if (r_state == S_IDLE && i_valid && o_ready) begin
                r_req  <= i_req;
                r_hit  <= 1'b0;
                // Complete needs no search: its scan starts at the busy row and takes the first row read.
                r_scan <= (i_req.operation == OP_COMPLETE) ? {1'b0, r_busy_idx} : '0;
            end
            if (r_state == S_SCAN) begin
                if (o_cmd.rd_en) r_scan <= r_scan + 1'b1;
                if (r_rd_pend && !r_hit && match) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_hit_ent <= i_rd_data;
                end
            end
            if (r_state == S_DONE) begin
                r_ovalid   <= 1'b1;
                r_rsp      <= n_rsp;
                r_fill     <= n_fill;
                r_pend     <= n_rsp.pending_count;
                r_busy     <= n_rsp.busy_flag;
                r_done     <= n_rsp.done_count;
                r_gate     <= n_rsp.gate_open;
                r_busy_idx <= n_busy_idx;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/tagged_io_request_queue_unit.sv
// Tagged I/O request queue: one request at a time, each scanning the table.
// Each request is a linear scan of the filled rows through the one read port
// of the table memory; complete starts at the busy row and needs no search.
// Throughput: one request per scan; the next is taken once the result is taken.
// Synchronous active-low reset clears all counters; the table needs no clearing.
module tagged_io_request_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  tiorq_pkg::t_req   i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output tiorq_pkg::t_rsp   o_rsp
);
    import tiorq_pkg::*;

    t_mem_cmd cmd;
    t_entry   rd_data;

    // Sequencer and its table memory.
    tiorq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid, .o_ready, .i_req,
        .o_valid, .i_ready, .o_rsp, .o_cmd(cmd), .i_rd_data(rd_data)
    );

    tiorq_table u_table (.i_clk, .i_cmd(cmd), .o_rd_data(rd_data));

endmodule

// File: hw/rtl/tiorq_checker.sv
// Port-level checks for the request queue, bound to the top level.
// Depends on tiorq_pkg.
module tiorq_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input tiorq_pkg::t_rsp o_rsp
);
    import tiorq_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // No new request while a result waits.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result waiting");

    // A dispatch always reports in-flight and busy.
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.dispatch_valid |->
            o_rsp.busy_flag && o_rsp.entry_status == ST_INFLIGHT)
        else $error("dispatch without busy");

    // Pending count never exceeds capacity.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.pending_count <= 7'(SlotCapacity))
        else $error("pending over capacity");

endmodule

bind tagged_io_request_queue_unit tiorq_checker u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready, .o_rsp
);
